// File: hdl/bilinear_image_scaler_unit_macros.svh
// Assertion macros for the bilinear image scaler checker
`ifndef BILINEAR_IMAGE_SCALER_UNIT_MACROS_SVH
`define BILINEAR_IMAGE_SCALER_UNIT_MACROS_SVH
// Assert that an antecedent implies a consequent on the same edge
`define BIS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bis check failed");
// Assert that an antecedent implies a consequent on the next edge
`define BIS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bis check failed");
`endif

// File: hdl/bis_pkg.sv
// Shared constants for the bilinear image scaler
`timescale 1ns / 1ps
`default_nettype none
package bis_pkg;
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_COMPUTE = 1'b1;
    localparam logic [1:0] REG_WIDTH = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_XSTEP = 2'd2;
    localparam logic [1:0] REG_YSTEP = 2'd3;
    localparam int STEP_W = 25;
    localparam int DIM_W = 9;
    localparam int DST_W = 10;
    localparam logic [7:0] PIX_MAX = 8'd255;
endpackage
`default_nettype wire

// File: hdl/bis_front.sv
// Front end: scales destination coordinates and classifies items
`timescale 1ns / 1ps
`default_nettype none
module bis_front #(
    parameter int XW = 8,
    parameter int YW = 8,
    parameter int FB = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    input  wire logic opcode,
    input  wire logic [7:0] src_col,
    input  wire logic [7:0] src_row,
    input  wire logic [7:0] pixel_in,
    input  wire logic [bis_pkg::DST_W-1:0] dst_col,
    input  wire logic [bis_pkg::DST_W-1:0] dst_row,
    input  wire logic [bis_pkg::STEP_W-1:0] x_step,
    input  wire logic [bis_pkg::STEP_W-1:0] y_step,
    input  wire logic [XW:0] width_cfg,
    input  wire logic [YW:0] height_cfg,
    output logic wr_en,
    output logic [XW+YW-1:0] wr_addr,
    output logic [7:0] wr_data,
    output logic q_push,
    output logic [XW-1:0] q_x0,
    output logic [XW-1:0] q_x1,
    output logic [YW-1:0] q_y0,
    output logic [YW-1:0] q_y1,
    output logic [FB-1:0] q_fx,
    output logic [FB-1:0] q_fy
);
    localparam int PW = bis_pkg::DST_W + bis_pkg::STEP_W;
    localparam int IW = PW - FB;
    logic        s1_valid_reg;
    logic [PW-1:0] sx_reg, sy_reg;
    logic [XW-1:0] lastc;
    logic [YW-1:0] lastr;
    logic [IW-1:0] ix, iy;
    logic [XW:0] wc;
    logic [YW:0] hc;

    // Register the load write and the raw products
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            wr_en <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid && opcode == bis_pkg::OP_COMPUTE;
            wr_en <= in_valid && opcode == bis_pkg::OP_LOAD
                && (32'(src_col) < (1 << XW)) && (32'(src_row) < (1 << YW));
        end
    end

    always_ff @(posedge clk)
    begin
        wr_addr <= {YW'(src_row), XW'(src_col)};
        wr_data <= pixel_in;
        sx_reg <= PW'(dst_col) * PW'(x_step);
        sy_reg <= PW'(dst_row) * PW'(y_step);
    end

    // Clamp the sizes to the store bounds, treat a zero size as one, and split off integer parts
    always_comb
    begin
        wc = width_cfg;
        hc = height_cfg;
        if (wc == '0) wc = (XW+1)'(1);
        if (hc == '0) hc = (YW+1)'(1);
        if (wc > (XW+1)'(1 << XW)) wc = (XW+1)'(1 << XW);
        if (hc > (YW+1)'(1 << YW)) hc = (YW+1)'(1 << YW);
        lastc = XW'(wc - 1'b1);
        lastr = YW'(hc - 1'b1);
        ix = sx_reg[PW-1:FB];
        iy = sy_reg[PW-1:FB];
    end

    // Produce neighbour coordinates and weights
    assign q_push = s1_valid_reg;
    assign q_x0 = (ix > IW'(lastc)) ? lastc : XW'(ix);
    assign q_y0 = (iy > IW'(lastr)) ? lastr : YW'(iy);
    assign q_x1 = (q_x0 == lastc) ? lastc : q_x0 + 1'b1;
    assign q_y1 = (q_y0 == lastr) ? lastr : q_y0 + 1'b1;
    assign q_fx = sx_reg[FB-1:0];
    assign q_fy = sy_reg[FB-1:0];
endmodule
`default_nettype wire

// File: hdl/bis_back.sv
// Back end: banked frame store reads and bilinear blend
`timescale 1ns / 1ps
`default_nettype none
module bis_back #(
    parameter int XW = 8,
    parameter int YW = 8,
    parameter int FB = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr_en,
    input  wire logic [XW+YW-1:0] wr_addr,
    input  wire logic [7:0] wr_data,
    input  wire logic adv,
    input  wire logic in_valid,
    input  wire logic [XW-1:0] x0,
    input  wire logic [XW-1:0] x1,
    input  wire logic [YW-1:0] y0,
    input  wire logic [YW-1:0] y1,
    input  wire logic [FB-1:0] fx,
    input  wire logic [FB-1:0] fy,
    output logic out_valid,
    output logic [7:0] pix
);
    localparam int DEPTH = 1 << (XW + YW);
    localparam int WW = FB + 1;
    localparam int HW = 8 + WW;
    localparam int SW = 8 + 2 * WW + 2;
    logic [7:0] mem_a [DEPTH];
    logic [7:0] mem_b [DEPTH];
    logic [7:0] mem_c [DEPTH];
    logic [7:0] mem_d [DEPTH];
    logic [7:0] a_reg, b_reg, c_reg, d_reg;
    logic [FB-1:0] fx1_reg, fy1_reg, fy2_reg;
    logic [HW-1:0] top_reg, bot_reg;
    logic [SW-1:0] sum_reg;
    logic [2:0] v_reg;
    logic [WW-1:0] one, wx0, wx1, wy0, wy1;
    logic [SW-1:0] r;

    // Four copies of the store, one per neighbour, and the blend pipeline registers
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_a[wr_addr] <= wr_data;
            mem_b[wr_addr] <= wr_data;
            mem_c[wr_addr] <= wr_data;
            mem_d[wr_addr] <= wr_data;
        end
        if (adv)
        begin
            a_reg <= mem_a[{y0, x0}];
            b_reg <= mem_b[{y0, x1}];
            c_reg <= mem_c[{y1, x0}];
            d_reg <= mem_d[{y1, x1}];
            fx1_reg <= fx;
            fy1_reg <= fy;
            top_reg <= HW'(a_reg) * HW'(wx0) + HW'(b_reg) * HW'(wx1);
            bot_reg <= HW'(c_reg) * HW'(wx0) + HW'(d_reg) * HW'(wx1);
            fy2_reg <= fy1_reg;
            sum_reg <= SW'(top_reg) * SW'(wy0) + SW'(bot_reg) * SW'(wy1);
        end
    end

    assign one = WW'(1) << FB;
    assign wx1 = WW'(fx1_reg);
    assign wx0 = one - wx1;
    assign wy1 = WW'(fy2_reg);
    assign wy0 = one - wy1;

    // Advance the valid pipe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v_reg <= '0;
        else if (adv) v_reg <= {v_reg[1:0], in_valid};
    end

    // Round half up and clamp
    assign r = (sum_reg + (SW'(1) << (2 * FB - 1))) >> (2 * FB);
    assign pix = (r > SW'(bis_pkg::PIX_MAX)) ? bis_pkg::PIX_MAX : r[7:0];
    assign out_valid = v_reg[2];
endmodule
`default_nettype wire

// File: hdl/bis_fifo.sv
// Small result queue decoupling the pipeline from the consumer
`timescale 1ns / 1ps
`default_nettype none
module bis_fifo #(
    parameter int AW = 3
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire logic [7:0] din,
    input  wire logic pop,
    output logic empty,
    output logic [7:0] dout,
    output logic [AW:0] count
);
    logic [7:0] buf_reg [1 << AW];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0] cnt_reg;
    logic do_pop;

    assign do_pop = pop && cnt_reg != '0;
    // Move pointers and count on each transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push) wp_reg <= wp_reg + 1'b1;
            if (do_pop) rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(do_pop);
        end
    end
    always_ff @(posedge clk)
    begin
        if (push) buf_reg[wp_reg] <= din;
    end
    assign empty = cnt_reg == '0;
    assign dout = buf_reg[rp_reg];
    assign count = cnt_reg;
endmodule
`default_nettype wire

// File: hdl/bilinear_image_scaler_unit.sv
// Compute results pass product, read and blend registers, then the queue.
// Throughput: one item per cycle unless full, via four banked read ports.
// Load items write the store one cycle after transfer and give no result.
// Full rises only when the result queue cannot take the items in flight.
// Reset clears control and configuration; the frame store is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module bilinear_image_scaler_unit #(
    parameter int MAX_WIDTH = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int FRAC_BITS = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    output logic full,
    input  wire logic opcode,
    input  wire logic [7:0] src_col,
    input  wire logic [7:0] src_row,
    input  wire logic [7:0] pixel_in,
    input  wire logic [9:0] dst_col,
    input  wire logic [9:0] dst_row,
    output logic empty,
    input  wire logic pop,
    output logic [7:0] pixel_out,
    input  wire logic cfg_valid,
    output logic cfg_ready,
    input  wire logic [1:0] cfg_index,
    input  wire logic [31:0] cfg_data
);
    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int FB = FRAC_BITS;
    localparam int AW = 3;
    logic [XW:0] width_reg;
    logic [YW:0] height_reg;
    logic [bis_pkg::STEP_W-1:0] xs_reg, ys_reg;
    logic wr_en, q_push, out_valid, accept;
    logic [XW+YW-1:0] wr_addr;
    logic [7:0] wr_data, pix;
    logic [XW-1:0] x0, x1;
    logic [YW-1:0] y0, y1;
    logic [FB-1:0] fx, fy;
    logic [AW:0] count;

    assign cfg_ready = 1'b1;
    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= (XW+1)'(MAX_WIDTH);
            height_reg <= (YW+1)'(MAX_HEIGHT);
            xs_reg <= bis_pkg::STEP_W'(1) << FB;
            ys_reg <= bis_pkg::STEP_W'(1) << FB;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                bis_pkg::REG_WIDTH:
                    width_reg <= (32'(cfg_data[8:0]) > MAX_WIDTH) ? (XW+1)'(MAX_WIDTH)
                        : (XW+1)'(cfg_data[8:0]);
                bis_pkg::REG_HEIGHT:
                    height_reg <= (32'(cfg_data[8:0]) > MAX_HEIGHT) ? (YW+1)'(MAX_HEIGHT)
                        : (YW+1)'(cfg_data[8:0]);
                bis_pkg::REG_XSTEP: xs_reg <= cfg_data[24:0];
                bis_pkg::REG_YSTEP: ys_reg <= cfg_data[24:0];
                default: ;
            endcase
        end
    end

    // Stall input when queue room does not cover items in flight
    assign full = count > (AW+1)'((1 << AW) - 5);
    assign accept = push && !full;

    bis_front #(.XW(XW), .YW(YW), .FB(FB)) u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(accept), .opcode(opcode),
        .src_col(src_col), .src_row(src_row), .pixel_in(pixel_in),
        .dst_col(dst_col), .dst_row(dst_row), .x_step(xs_reg), .y_step(ys_reg),
        .width_cfg(width_reg), .height_cfg(height_reg),
        .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data), .q_push(q_push),
        .q_x0(x0), .q_x1(x1), .q_y0(y0), .q_y1(y1), .q_fx(fx), .q_fy(fy)
    );

    bis_back #(.XW(XW), .YW(YW), .FB(FB)) u_back (
        .clk(clk), .rst_n(rst_n), .wr_en(wr_en), .wr_addr(wr_addr),
        .wr_data(wr_data), .adv(1'b1), .in_valid(q_push),
        .x0(x0), .x1(x1), .y0(y0), .y1(y1), .fx(fx), .fy(fy),
        .out_valid(out_valid), .pix(pix)
    );

    bis_fifo #(.AW(AW)) u_fifo (
        .clk(clk), .rst_n(rst_n), .push(out_valid), .din(pix), .pop(pop),
        .empty(empty), .dout(pixel_out), .count(count)
    );
endmodule
`default_nettype wire

// File: hdl/bis_checker.sv
// Port-level checker for the bilinear image scaler, with bind
`timescale 1ns / 1ps
`default_nettype none
`include "bilinear_image_scaler_unit_macros.svh"
module bis_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic push,
    input wire logic full,
    input wire logic empty,
    input wire logic pop,
    input wire logic opcode,
    input wire logic [7:0] pixel_out
);
    logic take_compute;

    // Flag a compute transfer on the input side
    assign take_compute = push && !full && opcode == bis_pkg::OP_COMPUTE;

    `BIS_ASSERT_NEXT(a_hold_out, clk, rst_n, !empty && !pop, !empty && $stable(pixel_out))
    `BIS_ASSERT_IMPL(a_full_has_data, clk, rst_n, full, !empty)
    `BIS_ASSERT_NEXT(a_no_early, clk, rst_n, empty, empty || $past(take_compute, 5))
endmodule
bind bilinear_image_scaler_unit bis_checker u_bis_checker (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full), .empty(empty),
    .pop(pop), .opcode(opcode), .pixel_out(pixel_out)
);
`default_nettype wire
